// File: rtl/core/smc_pkg.sv
// Shared types and constants of the system management controller register block
package smc_pkg;

	localparam int CMD_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int AV_W     = 3;
	localparam int COLOUR_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int VER_W    = 24;
	localparam int CHAL_W   = 32;
	localparam int WDT_W    = 8;

	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		OP_WRITE     = 3'd0,
		OP_READ      = 3'd1,
		OP_TICK      = 3'd2,
		OP_EJECT_BTN = 3'd3,
		OP_POWER_BTN = 3'd4,
		OP_PLUG      = 3'd5,
		OP_UNPLUG    = 3'd6,
		OP_SYS_RESET = 3'd7
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERSION   = 2'd0,
		CFG_CHALLENGE = 2'd1,
		CFG_WD_TICKS  = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		REG_NONE,
		REG_VERSION,
		REG_POWER,
		REG_TRAY,
		REG_CABLE,
		REG_LED_SRC,
		REG_LED_SEQ,
		REG_TRAY_CTRL,
		REG_ERROR,
		REG_IRQ_REASON,
		REG_LAST_CMD,
		REG_LAST_DATA,
		REG_EJECT_RST,
		REG_IRQ_EN,
		REG_SCRATCH,
		REG_CHALLENGE,
		REG_WD_STOP
	} reg_sel_t;

	typedef enum logic [1:0] {
		PWR_WARM,
		PWR_COLD,
		PWR_SHUTDOWN,
		PWR_BAD
	} pwr_t;

	// bus command bytes
	localparam logic [7:0] A_VERSION    = 8'h01;
	localparam logic [7:0] A_POWER      = 8'h02;
	localparam logic [7:0] A_TRAY       = 8'h03;
	localparam logic [7:0] A_CABLE      = 8'h04;
	localparam logic [7:0] A_LED_SRC    = 8'h07;
	localparam logic [7:0] A_LED_SEQ    = 8'h08;
	localparam logic [7:0] A_TRAY_CTRL  = 8'h0c;
	localparam logic [7:0] A_ERROR      = 8'h0e;
	localparam logic [7:0] A_IRQ_REASON = 8'h11;
	localparam logic [7:0] A_LAST_CMD   = 8'h16;
	localparam logic [7:0] A_LAST_DATA  = 8'h17;
	localparam logic [7:0] A_EJECT_RST  = 8'h19;
	localparam logic [7:0] A_IRQ_EN     = 8'h1a;
	localparam logic [7:0] A_SCRATCH    = 8'h1b;
	localparam logic [7:0] A_CHAL0      = 8'h1c;
	localparam logic [7:0] A_CHAL1      = 8'h1d;
	localparam logic [7:0] A_CHAL2      = 8'h1e;
	localparam logic [7:0] A_CHAL3      = 8'h1f;
	localparam logic [7:0] A_WD_STOP    = 8'h21;

	localparam logic [7:0] PWR_V_WARM = 8'h01;
	localparam logic [7:0] PWR_V_COLD = 8'h40;
	localparam logic [7:0] PWR_V_SHUT = 8'h80;

	localparam logic [7:0] TRAY_NO_DRIVE = 8'h70;
	localparam logic [7:0] TRAY_OPEN     = 8'h10;
	localparam logic [7:0] TRAY_MEDIA    = 8'h60;
	localparam logic [7:0] TRAY_EMPTY    = 8'h40;

	localparam logic [7:0] IRQ_POWER  = 8'h01;
	localparam logic [7:0] IRQ_PLUG   = 8'h08;
	localparam logic [7:0] IRQ_UNPLUG = 8'h10;
	localparam logic [7:0] IRQ_EJECT  = 8'h20;

	localparam logic [7:0] SEQ_TRAY  = 8'hC0;
	localparam logic [7:0] SEQ_RESET = 8'hF0;
	localparam logic [7:0] SEQ_OFF   = 8'h00;

	localparam logic [AV_W-1:0] CABLE_COMPOSITE = 3'd6;
	localparam logic [AV_W-1:0] CABLE_NONE      = 3'd7;
	localparam logic [7:0]      SCRATCH_RESET   = 8'h04;

	localparam logic [VER_W-1:0]  VERSION_DBX   = 24'h444258;
	localparam logic [VER_W-1:0]  VERSION_RESET = 24'd5255217;
	localparam logic [CHAL_W-1:0] CHAL_RESET    = 32'd1383263814;
	localparam logic [WDT_W-1:0]  WDT_RESET     = 8'd2;
	localparam logic              WD_RUN_RESET  = (VERSION_RESET != VERSION_DBX);

	typedef struct packed {
		op_t                 op;
		reg_sel_t            sel;
		pwr_t                pwr;
		logic [BYTE_W-1:0]   addr;
		logic [BYTE_W-1:0]   wdata;
		logic [AV_W-1:0]     avpack;
		logic                drive;
		logic [BYTE_W-1:0]   tray;
	} item_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} qstat_t;

endpackage

// File: rtl/core/smc_ifs.sv
// Valid/ready channel interfaces for request and response words
interface smc_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [smc_pkg::CMD_W-1:0]             cmd;
	logic [smc_pkg::BYTE_W-1:0]            reg_addr;
	logic [smc_pkg::BYTE_W-1:0]            wdata;
	logic [smc_pkg::AV_W-1:0]              avpack_code;
	logic                                  drive_present;
	logic                                  tray_open;
	logic                                  media_present;

	modport source (output valid, cmd, reg_addr, wdata, avpack_code, drive_present,
		tray_open, media_present, input ready);
	modport sink (input valid, cmd, reg_addr, wdata, avpack_code, drive_present,
		tray_open, media_present, output ready);
endinterface

interface smc_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [smc_pkg::BYTE_W-1:0]            rdata;
	logic [smc_pkg::COLOUR_W-1:0]          led_colour;
	logic                                  warm_reboot;
	logic                                  cold_reboot;
	logic                                  shutdown_req;
	logic                                  eject_req;
	logic                                  bad_power_value;

	modport source (output valid, rdata, led_colour, warm_reboot, cold_reboot,
		shutdown_req, eject_req, bad_power_value, input ready);
	modport sink (input valid, rdata, led_colour, warm_reboot, cold_reboot,
		shutdown_req, eject_req, bad_power_value, output ready);
endinterface

// File: rtl/core/system_mgmt_controller_regs.sv
// Top level of the system management controller register block
//
// channel  dir  handshake      word
// req      in   valid/ready    cmd, reg_addr, wdata, avpack_code, drive status
// rsp      out  valid/ready    rdata, led_colour, reboot/shutdown/eject/bad power
// cfg      in   cfg_we only    cfg_idx, cfg_wdata
//
// One word per cycle sustained while rsp is not stalled; rsp.valid rises
// once a word has passed the queue and the response register. The back end's
// single state update per word sets the rate. Reset is asynchronous.
// A stalled rsp holds the response register, then fills the two-entry queue,
// then drops req.ready.
module system_mgmt_controller_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	smc_req_if.sink                         req,
	smc_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	smc_pkg::item_t  push_item, pop_item;
	smc_pkg::qstat_t q_stat;
	logic            push, pop;

	smc_front u_front (
		.req  (req),
		.full (q_stat.full),
		.push (push),
		.item (push_item)
	);

	smc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	smc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_valid   (!q_stat.empty),
		.item      (pop_item),
		.pop       (pop),
		.rsp       (rsp)
	);

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !req.ready)
		else $error("request accepted into a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("back end took a word from an empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
		else $error("queue fill count lost a pushed word");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.warm_reboot, rsp.cold_reboot, rsp.shutdown_req,
			rsp.bad_power_value}))
		else $error("conflicting power requests in one response");

endmodule

// File: rtl/core/smc_front.sv
// Front end: accepts request words and decodes them into queue entries
module smc_front (
	smc_req_if.sink        req,
	input  logic           full,
	output logic           push,
	output smc_pkg::item_t item
);

	smc_pkg::reg_sel_t sel;
	smc_pkg::pwr_t     pwr;
	logic [smc_pkg::BYTE_W-1:0] tray;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		unique case (req.reg_addr) inside
			smc_pkg::A_VERSION:    sel = smc_pkg::REG_VERSION;
			smc_pkg::A_POWER:      sel = smc_pkg::REG_POWER;
			smc_pkg::A_TRAY:       sel = smc_pkg::REG_TRAY;
			smc_pkg::A_CABLE:      sel = smc_pkg::REG_CABLE;
			smc_pkg::A_LED_SRC:    sel = smc_pkg::REG_LED_SRC;
			smc_pkg::A_LED_SEQ:    sel = smc_pkg::REG_LED_SEQ;
			smc_pkg::A_TRAY_CTRL:  sel = smc_pkg::REG_TRAY_CTRL;
			smc_pkg::A_ERROR:      sel = smc_pkg::REG_ERROR;
			smc_pkg::A_IRQ_REASON: sel = smc_pkg::REG_IRQ_REASON;
			smc_pkg::A_LAST_CMD:   sel = smc_pkg::REG_LAST_CMD;
			smc_pkg::A_LAST_DATA:  sel = smc_pkg::REG_LAST_DATA;
			smc_pkg::A_EJECT_RST:  sel = smc_pkg::REG_EJECT_RST;
			smc_pkg::A_IRQ_EN:     sel = smc_pkg::REG_IRQ_EN;
			smc_pkg::A_SCRATCH:    sel = smc_pkg::REG_SCRATCH;
			smc_pkg::A_CHAL0, smc_pkg::A_CHAL1,
			smc_pkg::A_CHAL2, smc_pkg::A_CHAL3: sel = smc_pkg::REG_CHALLENGE;
			smc_pkg::A_WD_STOP:    sel = smc_pkg::REG_WD_STOP;
			default:               sel = smc_pkg::REG_NONE;
		endcase
	end

	always_comb begin
		unique case (req.wdata)
			smc_pkg::PWR_V_WARM: pwr = smc_pkg::PWR_WARM;
			smc_pkg::PWR_V_COLD: pwr = smc_pkg::PWR_COLD;
			smc_pkg::PWR_V_SHUT: pwr = smc_pkg::PWR_SHUTDOWN;
			default:             pwr = smc_pkg::PWR_BAD;
		endcase
	end

	always_comb begin
		if (!req.drive_present)
			tray = smc_pkg::TRAY_NO_DRIVE;
		else if (req.tray_open)
			tray = smc_pkg::TRAY_OPEN;
		else if (req.media_present)
			tray = smc_pkg::TRAY_MEDIA;
		else
			tray = smc_pkg::TRAY_EMPTY;
	end

	always_comb begin
		item.op     = smc_pkg::op_t'(req.cmd);
		item.sel    = sel;
		item.pwr    = pwr;
		item.addr   = req.reg_addr;
		item.wdata  = req.wdata;
		item.avpack = req.avpack_code;
		item.drive  = req.drive_present;
		item.tray   = tray;
	end

endmodule

// File: rtl/core/smc_queue.sv
// Short FIFO of decoded entries between front and back end
module smc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  smc_pkg::item_t push_item,
	input  logic           pop,
	output smc_pkg::item_t pop_item,
	output smc_pkg::qstat_t stat
);

	smc_pkg::item_t mem_q [smc_pkg::QDEPTH];
	logic [smc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [smc_pkg::QCNT_W-1:0] count_q;

	localparam logic [smc_pkg::QPTR_W-1:0] PTR_LAST = smc_pkg::QPTR_W'(smc_pkg::QDEPTH - 1);
	localparam logic [smc_pkg::QPTR_W-1:0] PTR_ONE  = smc_pkg::QPTR_W'(1);
	localparam logic [smc_pkg::QCNT_W-1:0] CNT_ONE  = smc_pkg::QCNT_W'(1);
	localparam logic [smc_pkg::QCNT_W-1:0] CNT_FULL = smc_pkg::QCNT_W'(smc_pkg::QDEPTH);

	assign pop_item   = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			if (push && !pop)
				count_q <= count_q + CNT_ONE;
			else if (pop && !push)
				count_q <= count_q - CNT_ONE;
		end
	end

endmodule

// File: rtl/core/smc_back.sv
// Back end: register file, LED sequencer, watchdog and response register
module smc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            q_valid,
	input  smc_pkg::item_t                  item,
	output logic                            pop,
	smc_rsp_if.source                       rsp
);

	typedef struct packed {
		logic [7:0]               last_cmd;
		logic [7:0]               last_data;
		logic [7:0]               error;
		logic                     irq_en;
		logic [7:0]               irq_reason;
		logic [7:0]               led_src;
		logic [7:0]               led_user;
		logic [7:0]               led_def;
		logic [1:0]               led_phase;
		logic [1:0]               led_now;
		logic [smc_pkg::AV_W-1:0] cable;
		logic                     ej_resets;
		logic [7:0]               scratch;
		logic [1:0]               vpos;
		logic                     wd_run;
		logic [7:0]               wd_cnt;
	} state_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       warm;
		logic       cold;
		logic       shut;
		logic       eject;
		logic       bad;
	} res_t;

	localparam state_t STATE_RESET = '{
		last_cmd:   8'h00,
		last_data:  8'h00,
		error:      8'h00,
		irq_en:     1'b0,
		irq_reason: 8'h00,
		led_src:    8'h00,
		led_user:   smc_pkg::SEQ_RESET,
		led_def:    smc_pkg::SEQ_RESET,
		led_phase:  2'd0,
		led_now:    2'd0,
		cable:      smc_pkg::CABLE_COMPOSITE,
		ej_resets:  1'b1,
		scratch:    smc_pkg::SCRATCH_RESET,
		vpos:       2'd0,
		wd_run:     smc_pkg::WD_RUN_RESET,
		wd_cnt:     8'h00
	};

	state_t st_q, st_d;
	res_t   res_q, res_d;
	logic   out_valid_q;

	logic [smc_pkg::VER_W-1:0]  version_q;
	logic [smc_pkg::CHAL_W-1:0] chal_q;
	logic [smc_pkg::WDT_W-1:0]  wd_ticks_q;

	logic       is_dbx;
	logic [1:0] pos, phase_n;
	logic [7:0] seq, cnt_n, lim;

	assign pop    = q_valid && (!out_valid_q || rsp.ready);
	assign is_dbx = (version_q == smc_pkg::VERSION_DBX);

	always_comb begin
		st_d    = st_q;
		res_d   = '0;
		pos     = (st_q.vpos == 2'd3) ? 2'd0 : st_q.vpos;
		phase_n = st_q.led_phase + 2'd1;
		seq     = (st_q.led_src == 8'h00) ? st_q.led_def : st_q.led_user;
		cnt_n   = (st_q.wd_cnt != 8'hFF) ? st_q.wd_cnt + 8'd1 : st_q.wd_cnt;
		lim     = (wd_ticks_q == '0) ? 8'd1 : wd_ticks_q;

		unique case (item.op)
			smc_pkg::OP_WRITE: begin
				st_d.last_cmd  = item.addr;
				st_d.last_data = item.wdata;
				case (item.sel)
					smc_pkg::REG_VERSION:  st_d.vpos = 2'd0;
					smc_pkg::REG_POWER: begin
						unique case (item.pwr)
							smc_pkg::PWR_WARM: begin
								st_d.led_def = smc_pkg::SEQ_OFF;
								res_d.warm   = 1'b1;
							end
							smc_pkg::PWR_COLD: begin
								st_d.led_def = smc_pkg::SEQ_OFF;
								res_d.cold   = 1'b1;
							end
							smc_pkg::PWR_SHUTDOWN: begin
								st_d.led_def = smc_pkg::SEQ_OFF;
								res_d.shut   = 1'b1;
							end
							default: res_d.bad = 1'b1;
						endcase
					end
					smc_pkg::REG_LED_SRC:  st_d.led_src  = item.wdata;
					smc_pkg::REG_LED_SEQ:  st_d.led_user = item.wdata;
					smc_pkg::REG_TRAY_CTRL: begin
						if (item.drive) begin
							st_d.led_def = smc_pkg::SEQ_TRAY;
							res_d.eject  = (item.wdata == 8'h00);
						end
					end
					smc_pkg::REG_ERROR:     st_d.error     = item.wdata;
					smc_pkg::REG_EJECT_RST: st_d.ej_resets = (item.wdata == 8'h00);
					smc_pkg::REG_IRQ_EN: begin
						if (item.wdata == 8'h00)
							st_d.irq_en = 1'b1;
					end
					smc_pkg::REG_SCRATCH:   st_d.scratch = item.wdata;
					smc_pkg::REG_WD_STOP:   st_d.wd_run  = 1'b0;
					default: ;
				endcase
			end
			smc_pkg::OP_READ: begin
				case (item.sel)
					smc_pkg::REG_VERSION: begin
						case (pos)
							2'd0:    res_d.rdata = version_q[23:16];
							2'd1:    res_d.rdata = version_q[15:8];
							default: res_d.rdata = version_q[7:0];
						endcase
						st_d.vpos = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
					end
					smc_pkg::REG_TRAY:       res_d.rdata = item.tray;
					smc_pkg::REG_CABLE:      res_d.rdata = {5'd0, st_q.cable};
					smc_pkg::REG_ERROR:      res_d.rdata = st_q.error;
					smc_pkg::REG_IRQ_REASON: res_d.rdata = st_q.irq_reason;
					smc_pkg::REG_LAST_CMD:   res_d.rdata = st_q.last_cmd;
					smc_pkg::REG_LAST_DATA:  res_d.rdata = st_q.last_data;
					smc_pkg::REG_SCRATCH:    res_d.rdata = st_q.scratch;
					smc_pkg::REG_CHALLENGE: begin
						if (!is_dbx) begin
							case (item.addr[1:0])
								2'd0:    res_d.rdata = chal_q[31:24];
								2'd1:    res_d.rdata = chal_q[23:16];
								2'd2:    res_d.rdata = chal_q[15:8];
								default: res_d.rdata = chal_q[7:0];
							endcase
						end
					end
					default: ;
				endcase
			end
			smc_pkg::OP_TICK: begin
				st_d.led_phase = phase_n;
				st_d.led_now   = {seq[{1'b1, phase_n}], seq[{1'b0, phase_n}]};
				if (st_q.wd_run) begin
					st_d.wd_cnt = cnt_n;
					if (cnt_n >= lim) begin
						st_d.wd_run  = 1'b0;
						st_d.led_def = smc_pkg::SEQ_OFF;
						res_d.warm   = 1'b1;
					end
				end
			end
			smc_pkg::OP_EJECT_BTN: begin
				if (st_q.ej_resets) begin
					st_d.led_def = smc_pkg::SEQ_OFF;
					res_d.warm   = 1'b1;
				end else if (st_q.irq_en) begin
					st_d.irq_reason = smc_pkg::IRQ_EJECT;
				end
				if (item.drive) begin
					st_d.led_def = smc_pkg::SEQ_TRAY;
					res_d.eject  = 1'b1;
				end
			end
			smc_pkg::OP_POWER_BTN: begin
				if (st_q.irq_en)
					st_d.irq_reason = smc_pkg::IRQ_POWER;
			end
			smc_pkg::OP_PLUG: begin
				st_d.cable = item.avpack;
				if (st_q.irq_en)
					st_d.irq_reason = smc_pkg::IRQ_PLUG;
			end
			smc_pkg::OP_UNPLUG: begin
				st_d.cable = smc_pkg::CABLE_NONE;
				if (st_q.irq_en)
					st_d.irq_reason = smc_pkg::IRQ_UNPLUG;
			end
			smc_pkg::OP_SYS_RESET: begin
				if (!is_dbx) begin
					st_d.wd_run = 1'b1;
					st_d.wd_cnt = 8'h00;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RESET;
			out_valid_q <= 1'b0;
			version_q   <= smc_pkg::VERSION_RESET;
			chal_q      <= smc_pkg::CHAL_RESET;
			wd_ticks_q  <= smc_pkg::WDT_RESET;
		end else begin
			if (pop)
				st_q <= st_d;
			if (pop)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					smc_pkg::CFG_VERSION:   version_q  <= cfg_wdata[smc_pkg::VER_W-1:0];
					smc_pkg::CFG_CHALLENGE: chal_q     <= cfg_wdata[smc_pkg::CHAL_W-1:0];
					smc_pkg::CFG_WD_TICKS:  wd_ticks_q <= cfg_wdata[smc_pkg::WDT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res_d;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.rdata           = res_q.rdata;
	assign rsp.led_colour      = st_q.led_now;
	assign rsp.warm_reboot     = res_q.warm;
	assign rsp.cold_reboot     = res_q.cold;
	assign rsp.shutdown_req    = res_q.shut;
	assign rsp.eject_req       = res_q.eject;
	assign rsp.bad_power_value = res_q.bad;

endmodule

// File: dv/tb.sv
// Self-checking testbench of the system management controller register block
module tb;

	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_WORDS  = 370;

	localparam logic [7:0] A_FAN_CFG   = 8'h05;
	localparam logic [7:0] A_FAN_RPM   = 8'h06;
	localparam logic [7:0] A_AUDIO     = 8'h0b;
	localparam logic [7:0] A_RESP_ZERO = 8'h20;

	typedef struct packed {
		smc_pkg::op_t cmd;
		logic [7:0]   reg_addr;
		logic [7:0]   wdata;
		logic [2:0]   avpack;
		logic         drive;
		logic         tray_open;
		logic         media;
	} req_word_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic [1:0] colour;
		logic       warm;
		logic       cold;
		logic       shut;
		logic       eject;
		logic       bad;
	} rsp_word_t;

	class smc_response_predictor;
		logic [23:0] version;
		logic [31:0] challenge;
		logic [7:0]  wd_limit;
		logic [7:0]  last_cmd, last_data, err_code, irq_reason;
		logic [7:0]  led_src, user_seq, default_seq;
		logic [7:0]  fan_rpm, fan_cfg, cable, scratch, wd_count;
		logic        audio_clamp, irq_en, eject_resets, wd_running;
		logic [1:0]  phase, colour, version_pos;
		rsp_word_t   due_rsp[$];
		int          checked;
		int          errors;

		function new();
			set_regs(smc_pkg::VERSION_RESET, smc_pkg::CHAL_RESET, smc_pkg::WDT_RESET);
			last_cmd = '0; last_data = '0; err_code = '0; irq_reason = '0;
			led_src = '0; user_seq = smc_pkg::SEQ_RESET; default_seq = smc_pkg::SEQ_RESET;
			fan_rpm = '0; fan_cfg = '0; cable = {5'd0, smc_pkg::CABLE_COMPOSITE};
			scratch = smc_pkg::SCRATCH_RESET; wd_count = '0;
			audio_clamp = 1'b0; irq_en = 1'b0; eject_resets = 1'b1;
			wd_running = (smc_pkg::VERSION_RESET != smc_pkg::VERSION_DBX);
			phase = '0; colour = '0; version_pos = '0;
			checked = 0; errors = 0;
		endfunction

		function void set_regs(logic [23:0] ver, logic [31:0] chal, logic [7:0] wdt);
			version = ver;
			challenge = chal;
			wd_limit = wdt;
		endfunction

		function int pending();
			return due_rsp.size();
		endfunction

		function void note_word(req_word_t w);
			rsp_word_t  e;
			logic [7:0] seq;
			logic [7:0] lim;
			e = '0;
			case (w.cmd)
			smc_pkg::OP_WRITE: begin
				last_cmd = w.reg_addr;
				last_data = w.wdata;
				case (w.reg_addr)
				smc_pkg::A_VERSION: version_pos = '0;
				smc_pkg::A_POWER: begin
					if (w.wdata == smc_pkg::PWR_V_WARM) begin
						default_seq = smc_pkg::SEQ_OFF;
						e.warm = 1'b1;
					end else if (w.wdata == smc_pkg::PWR_V_COLD) begin
						default_seq = smc_pkg::SEQ_OFF;
						e.cold = 1'b1;
					end else if (w.wdata == smc_pkg::PWR_V_SHUT) begin
						default_seq = smc_pkg::SEQ_OFF;
						e.shut = 1'b1;
					end else begin
						e.bad = 1'b1;
					end
				end
				A_FAN_CFG: fan_cfg = w.wdata;
				A_FAN_RPM: fan_rpm = w.wdata;
				smc_pkg::A_LED_SRC: led_src = w.wdata;
				smc_pkg::A_LED_SEQ: user_seq = w.wdata;
				A_AUDIO: audio_clamp = (w.wdata != 8'h00);
				smc_pkg::A_TRAY_CTRL: begin
					if (w.drive) begin
						default_seq = smc_pkg::SEQ_TRAY;
						e.eject = (w.wdata == 8'h00);
					end
				end
				smc_pkg::A_ERROR: err_code = w.wdata;
				smc_pkg::A_EJECT_RST: eject_resets = (w.wdata == 8'h00);
				smc_pkg::A_IRQ_EN: if (w.wdata == 8'h00) irq_en = 1'b1;
				smc_pkg::A_SCRATCH: scratch = w.wdata;
				smc_pkg::A_WD_STOP: wd_running = 1'b0;
				default: ;
				endcase
			end
			smc_pkg::OP_READ: begin
				case (w.reg_addr)
				smc_pkg::A_VERSION: begin
					e.rdata = version[8*(2 - version_pos) +: 8];
					version_pos = (version_pos == 2'd2) ? 2'd0 : version_pos + 2'd1;
				end
				smc_pkg::A_TRAY: begin
					if (!w.drive)
						e.rdata = smc_pkg::TRAY_NO_DRIVE;
					else if (w.tray_open)
						e.rdata = smc_pkg::TRAY_OPEN;
					else
						e.rdata = w.media ? smc_pkg::TRAY_MEDIA : smc_pkg::TRAY_EMPTY;
				end
				smc_pkg::A_CABLE: e.rdata = cable;
				smc_pkg::A_ERROR: e.rdata = err_code;
				smc_pkg::A_IRQ_REASON: e.rdata = irq_reason;
				smc_pkg::A_LAST_CMD: e.rdata = last_cmd;
				smc_pkg::A_LAST_DATA: e.rdata = last_data;
				smc_pkg::A_SCRATCH: e.rdata = scratch;
				smc_pkg::A_CHAL0, smc_pkg::A_CHAL1, smc_pkg::A_CHAL2, smc_pkg::A_CHAL3: begin
					if (version == smc_pkg::VERSION_DBX)
						e.rdata = 8'h00;
					else
						e.rdata = challenge[8*(3 - w.reg_addr[1:0]) +: 8];
				end
				default: e.rdata = 8'h00;
				endcase
			end
			smc_pkg::OP_TICK: begin
				phase = phase + 2'd1;
				seq = (led_src == 8'h00) ? default_seq : user_seq;
				colour = {seq[4 + phase], seq[phase]};
				if (wd_running) begin
					lim = (wd_limit == 8'h00) ? 8'd1 : wd_limit;
					if (wd_count != 8'hFF)
						wd_count = wd_count + 8'd1;
					if (wd_count >= lim) begin
						wd_running = 1'b0;
						default_seq = smc_pkg::SEQ_OFF;
						e.warm = 1'b1;
					end
				end
			end
			smc_pkg::OP_EJECT_BTN: begin
				if (eject_resets) begin
					default_seq = smc_pkg::SEQ_OFF;
					e.warm = 1'b1;
				end else if (irq_en) begin
					irq_reason = smc_pkg::IRQ_EJECT;
				end
				if (w.drive) begin
					default_seq = smc_pkg::SEQ_TRAY;
					e.eject = 1'b1;
				end
			end
			smc_pkg::OP_POWER_BTN: if (irq_en) irq_reason = smc_pkg::IRQ_POWER;
			smc_pkg::OP_PLUG: begin
				cable = {5'd0, w.avpack};
				if (irq_en) irq_reason = smc_pkg::IRQ_PLUG;
			end
			smc_pkg::OP_UNPLUG: begin
				if (irq_en) irq_reason = smc_pkg::IRQ_UNPLUG;
				cable = {5'd0, smc_pkg::CABLE_NONE};
			end
			smc_pkg::OP_SYS_RESET: begin
				if (version != smc_pkg::VERSION_DBX) begin
					wd_running = 1'b1;
					wd_count = 8'h00;
				end
			end
			default: ;
			endcase
			e.colour = colour;
			due_rsp.push_back(e);
		endfunction

		task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
			errors++;
			$display("MISMATCH response %0d %s: got %h, expected %h", checked, what, got,
				want);
		endtask

		task check_word(rsp_word_t got);
			rsp_word_t e;
			if (due_rsp.size() == 0) begin
				report_mismatch("unexpected word, rdata", got.rdata, 8'h00);
				return;
			end
			e = due_rsp.pop_front();
			checked++;
			if (got.rdata !== e.rdata)
				report_mismatch("rdata", got.rdata, e.rdata);
			if (got.colour !== e.colour)
				report_mismatch("led_colour", {6'd0, got.colour}, {6'd0, e.colour});
			if (got.warm !== e.warm)
				report_mismatch("warm_reboot", {7'd0, got.warm}, {7'd0, e.warm});
			if (got.cold !== e.cold)
				report_mismatch("cold_reboot", {7'd0, got.cold}, {7'd0, e.cold});
			if (got.shut !== e.shut)
				report_mismatch("shutdown_req", {7'd0, got.shut}, {7'd0, e.shut});
			if (got.eject !== e.eject)
				report_mismatch("eject_req", {7'd0, got.eject}, {7'd0, e.eject});
			if (got.bad !== e.bad)
				report_mismatch("bad_power_value", {7'd0, got.bad}, {7'd0, e.bad});
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [smc_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [smc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	smc_req_if req_ch ();
	smc_rsp_if rsp_ch ();

	smc_response_predictor sb = new();

	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int words_sent = 0;
	int settings_run = 1;

	system_mgmt_controller_regs u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_word_t mk(smc_pkg::op_t c, logic [7:0] a, logic [7:0] d,
			logic [2:0] av, logic dr, logic op, logic md);
		req_word_t w;
		w.cmd = c; w.reg_addr = a; w.wdata = d; w.avpack = av;
		w.drive = dr; w.tray_open = op; w.media = md;
		return w;
	endfunction

	function automatic req_word_t random_word();
		req_word_t w;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)      w.cmd = smc_pkg::OP_WRITE;
		else if (r < 55) w.cmd = smc_pkg::OP_READ;
		else if (r < 75) w.cmd = smc_pkg::OP_TICK;
		else if (r < 80) w.cmd = smc_pkg::OP_EJECT_BTN;
		else if (r < 84) w.cmd = smc_pkg::OP_POWER_BTN;
		else if (r < 89) w.cmd = smc_pkg::OP_PLUG;
		else if (r < 93) w.cmd = smc_pkg::OP_UNPLUG;
		else             w.cmd = smc_pkg::OP_SYS_RESET;
		case ($urandom_range(0, 27))
		0:  w.reg_addr = smc_pkg::A_VERSION;
		1:  w.reg_addr = smc_pkg::A_POWER;
		2:  w.reg_addr = smc_pkg::A_TRAY;
		3:  w.reg_addr = smc_pkg::A_CABLE;
		4:  w.reg_addr = A_FAN_CFG;
		5:  w.reg_addr = A_FAN_RPM;
		6:  w.reg_addr = smc_pkg::A_LED_SRC;
		7:  w.reg_addr = smc_pkg::A_LED_SEQ;
		8:  w.reg_addr = A_AUDIO;
		9:  w.reg_addr = smc_pkg::A_TRAY_CTRL;
		10: w.reg_addr = smc_pkg::A_ERROR;
		11: w.reg_addr = smc_pkg::A_IRQ_REASON;
		12: w.reg_addr = smc_pkg::A_LAST_CMD;
		13: w.reg_addr = smc_pkg::A_LAST_DATA;
		14: w.reg_addr = smc_pkg::A_EJECT_RST;
		15: w.reg_addr = smc_pkg::A_IRQ_EN;
		16: w.reg_addr = smc_pkg::A_SCRATCH;
		17: w.reg_addr = smc_pkg::A_CHAL0;
		18: w.reg_addr = smc_pkg::A_CHAL1;
		19: w.reg_addr = smc_pkg::A_CHAL2;
		20: w.reg_addr = smc_pkg::A_CHAL3;
		21: w.reg_addr = A_RESP_ZERO;
		22: w.reg_addr = smc_pkg::A_WD_STOP;
		default: w.reg_addr = 8'($urandom_range(0, 255));
		endcase
		w.wdata = 8'($urandom_range(0, 255));
		if (w.cmd == smc_pkg::OP_WRITE && $urandom_range(0, 1) == 1) begin
			case (w.reg_addr)
			smc_pkg::A_POWER: begin
				case ($urandom_range(0, 2))
				0: w.wdata = smc_pkg::PWR_V_WARM;
				1: w.wdata = smc_pkg::PWR_V_COLD;
				default: w.wdata = smc_pkg::PWR_V_SHUT;
				endcase
			end
			smc_pkg::A_TRAY_CTRL, smc_pkg::A_EJECT_RST, smc_pkg::A_IRQ_EN,
			smc_pkg::A_LED_SRC: w.wdata = 8'h00;
			default: ;
			endcase
		end
		w.avpack = 3'($urandom_range(0, 7));
		w.drive = ($urandom_range(0, 3) != 0);
		w.tray_open = 1'($urandom_range(0, 1));
		w.media = 1'($urandom_range(0, 1));
		return w;
	endfunction

	task automatic send_word(input req_word_t w);
		int gap;
		if ($urandom_range(0, 149) == 0)
			send_idle = !send_idle;
		gap = pick_gap(send_idle);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= w.cmd;
		req_ch.reg_addr <= w.reg_addr;
		req_ch.wdata <= w.wdata;
		req_ch.avpack_code <= w.avpack;
		req_ch.drive_present <= w.drive;
		req_ch.tray_open <= w.tray_open;
		req_ch.media_present <= w.media;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_word(w);
		words_sent++;
	endtask

	// hold off until every outstanding word has come back, then let the pipe settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [23:0] ver, input logic [31:0] chal,
			input logic [7:0] wdt);
		cfg_we <= 1'b1;
		cfg_idx <= smc_pkg::CFG_VERSION;
		cfg_wdata <= {8'h00, ver};
		@(posedge clk);
		cfg_idx <= smc_pkg::CFG_CHALLENGE;
		cfg_wdata <= chal;
		@(posedge clk);
		cfg_idx <= smc_pkg::CFG_WD_TICKS;
		cfg_wdata <= {24'h000000, wdt};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(ver, chal, wdt);
		settings_run++;
	endtask

	task automatic run_random(input int n, input int pause_at);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain();
			send_word(random_word());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_word({rsp_ch.rdata, rsp_ch.led_colour, rsp_ch.warm_reboot,
				rsp_ch.cold_reboot, rsp_ch.shutdown_req, rsp_ch.eject_req,
				rsp_ch.bad_power_value});
	end

	initial begin : rsp_stall
		int n;
		rsp_ch.ready = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 199) == 0)
				recv_idle = !recv_idle;
			n = pick_gap(recv_idle);
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : run_limit
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = smc_pkg::CFG_VERSION;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = smc_pkg::OP_WRITE;
		req_ch.reg_addr = '0;
		req_ch.wdata = '0;
		req_ch.avpack_code = '0;
		req_ch.drive_present = 1'b0;
		req_ch.tray_open = 1'b0;
		req_ch.media_present = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// version rotation, tray states, interrupts, power values, watchdog expiry
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_VERSION, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_VERSION, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_VERSION, 8'hFF, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_VERSION, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_TRAY, 8'h00, 3'd0, 1'b0, 1'b1, 1'b1));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_TRAY, 8'h00, 3'd0, 1'b1, 1'b1, 1'b1));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_TRAY, 8'h00, 3'd0, 1'b1, 1'b0, 1'b1));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_TRAY, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_CHAL3, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_IRQ_EN, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_POWER_BTN, 8'h00, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_PLUG, 8'h00, 8'h00, 3'd7, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_UNPLUG, 8'h00, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_READ, smc_pkg::A_IRQ_REASON, 8'h00, 3'd0, 1'b1, 1'b0,
			1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_EJECT_RST, 8'hFF, 3'd0, 1'b1, 1'b0,
			1'b0));
		send_word(mk(smc_pkg::OP_EJECT_BTN, 8'h00, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_POWER, smc_pkg::PWR_V_WARM, 3'd0, 1'b1,
			1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_POWER, smc_pkg::PWR_V_COLD, 3'd0, 1'b1,
			1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_POWER, smc_pkg::PWR_V_SHUT, 3'd0, 1'b1,
			1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_POWER, 8'hFF, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, A_RESP_ZERO, 8'h55, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, 8'hFF, 8'hFF, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_READ, 8'hFF, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_TRAY_CTRL, 8'h00, 3'd0, 1'b1, 1'b0,
			1'b0));
		send_word(mk(smc_pkg::OP_TICK, 8'h00, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_TICK, 8'h00, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_SYS_RESET, 8'h00, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));
		send_word(mk(smc_pkg::OP_WRITE, smc_pkg::A_WD_STOP, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0));

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				drain();
				case (p)
				1: program_regs(smc_pkg::VERSION_DBX, 32'h00000000, 8'd1);
				2: program_regs(24'hFFFFFF, 32'hFFFFFFFF, 8'd255);
				3: program_regs(24'h000000, $urandom, 8'($urandom_range(3, 12)));
				default: program_regs(24'($urandom), $urandom, 8'd1);
				endcase
			end
			run_random(PHASE_WORDS, (p == 2) ? PHASE_WORDS / 2 : -1);
		end
		drain();
		repeat (8) @(posedge clk);

		$display("Run covered %0d request words under %0d register settings", words_sent,
			settings_run);
		$display("%0d responses checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/smc_pkg.sv
rtl/core/smc_ifs.sv
rtl/core/smc_front.sv
rtl/core/smc_queue.sv
rtl/core/smc_back.sv
rtl/core/system_mgmt_controller_regs.sv
dv/tb.sv
